[rtl/core/bvm_pkg.sv]
package bvm_pkg;

  localparam int RegCount   = 16;
  localparam int StackWords = 256;
  localparam int RegIdxW    = $clog2(RegCount);
  localparam int StackIdxW  = $clog2(StackWords);
  localparam int DepthW     = StackIdxW + 1;

  localparam logic [5:0] OP_EXIT  = 6'h01;
  localparam logic [5:0] OP_STORE = 6'h04;
  localparam logic [5:0] OP_LOAD  = 6'h05;
  localparam logic [5:0] OP_PUSH  = 6'h06;
  localparam logic [5:0] OP_POP   = 6'h07;
  localparam logic [5:0] OP_COPY  = 6'h08;
  localparam logic [5:0] OP_CASL  = 6'h0b;
  localparam logic [5:0] OP_ADDA  = 6'h0c;
  localparam logic [5:0] OP_SUBA  = 6'h0d;
  localparam logic [5:0] OP_ANDA  = 6'h0e;
  localparam logic [5:0] OP_ORA   = 6'h0f;
  localparam logic [5:0] OP_ADD   = 6'h10;
  localparam logic [5:0] OP_SUB   = 6'h11;
  localparam logic [5:0] OP_MUL   = 6'h12;
  localparam logic [5:0] OP_DIV   = 6'h13;
  localparam logic [5:0] OP_ADDI  = 6'h14;
  localparam logic [5:0] OP_SUBI  = 6'h15;
  localparam logic [5:0] OP_MULI  = 6'h16;
  localparam logic [5:0] OP_DIVI  = 6'h17;
  localparam logic [5:0] OP_GT    = 6'h18;
  localparam logic [5:0] OP_GE    = 6'h19;
  localparam logic [5:0] OP_EQ    = 6'h1a;
  localparam logic [5:0] OP_CONST = 6'h1b;
  localparam logic [5:0] OP_LAND  = 6'h1c;
  localparam logic [5:0] OP_LOR   = 6'h1d;
  localparam logic [5:0] OP_NOT   = 6'h1e;
  localparam logic [5:0] OP_GOTO  = 6'h20;
  localparam logic [5:0] OP_BACK  = 6'h21;
  localparam logic [5:0] OP_IFGT  = 6'h24;
  localparam logic [5:0] OP_IFGE  = 6'h25;
  localparam logic [5:0] OP_IFEQ  = 6'h26;
  localparam logic [5:0] OP_IOUT  = 6'h27;
  localparam logic [5:0] OP_IIN   = 6'h28;
  localparam logic [5:0] OP_CALL  = 6'h2c;
  localparam logic [5:0] OP_RET   = 6'h2d;
  localparam logic [5:0] OP_SHLR  = 6'h30;
  localparam logic [5:0] OP_SHRR  = 6'h31;
  localparam logic [5:0] OP_SHLI  = 6'h34;
  localparam logic [5:0] OP_SHRI  = 6'h35;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_DIV0  = 3'd1;
  localparam logic [2:0] FLT_OVER  = 3'd2;
  localparam logic [2:0] FLT_UNDER = 3'd3;
  localparam logic [2:0] FLT_INDEX = 3'd4;
  localparam logic [2:0] FLT_OPC   = 3'd5;

  // Operand use: bit 0 a, bit 1 b, bit 2 c, bit 3 unsupported opcode.
  function automatic logic [3:0] operand_use(input logic [5:0] op);
    logic [3:0] u;
    u = 4'b1000;
    case (op)
      6'h00, 6'h03, 6'h09, 6'h1f, 6'h22, 6'h23, 6'h2e, 6'h2f, 6'h32, 6'h33,
      6'h36, 6'h37, 6'h01, 6'h20, 6'h21, 6'h2c, 6'h2d: u = 4'b0000;
      6'h04: u = 4'b0010;
      6'h05, 6'h06, 6'h07, 6'h1b, 6'h27, 6'h28: u = 4'b0001;
      6'h08, 6'h0c, 6'h0d, 6'h0e, 6'h0f, 6'h14, 6'h15, 6'h16, 6'h17, 6'h1e,
      6'h34, 6'h35: u = 4'b0011;
      6'h0b, 6'h10, 6'h11, 6'h12, 6'h13, 6'h18, 6'h19, 6'h1a, 6'h1c, 6'h1d,
      6'h30, 6'h31: u = 4'b0111;
      6'h24, 6'h25, 6'h26: u = 4'b0110;
      default: u = 4'b1000;
    endcase
    return u;
  endfunction

  typedef enum logic [3:0] {
    DC_NONE, DC_LATCH, DC_DECODE, DC_DIV_START, DC_STK_RD, DC_CALL_BASE,
    DC_CALL_ZERO, DC_CALL_RET, DC_RET_RD_SAVED, DC_EXEC
  } dp_cmd_t;

  typedef struct packed {
    logic          call_fit;
    logic          bad_idx;
    logic          bad_op;
    logic          div_busy;
    logic          zero_done;
    logic [5:0]    op;
  } dp_status_t;

endpackage

[rtl/core/bvm_ram.sv]
module bvm_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bvm_div.sv]
module bvm_div
  import bvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic [32:0] trial;

  assign trial = {rem, quotient[31]} - {1'b0, dvs};

  // Restoring division, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= 6'd32;
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem      <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= {rem[30:0], quotient[31]};
        quotient <= {quotient[30:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/bvm_datapath.sv]
module bvm_datapath
  import bvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic [5:0]  command,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic [31:0] operand_c,
  input  logic [31:0] input_value,
  output logic [31:0] res_next_pc,
  output logic        res_out_valid,
  output logic [31:0] res_out_value,
  output logic        res_halted,
  output logic [2:0]  res_fault
);

  logic [31:0] pc;
  logic [31:0] regs [RegCount];
  logic [DepthW-1:0] depth;
  logic [DepthW-1:0] fbase;
  logic        halt;

  logic [5:0]  op;
  logic [31:0] a, b, c, inval;
  logic [31:0] ra, rb, rc;
  logic [31:0] stk_word;
  logic [31:0] zcount;
  logic [DepthW-1:0] zaddr;

  logic        ram_we;
  logic [StackIdxW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  logic        div_start, div_busy;
  logic [31:0] div_q;

  logic [3:0]  use_bits;
  logic        bad_a, bad_b, bad_c;
  logic [32:0] frame_idx;
  logic        call_fit;

  assign use_bits = operand_use(op);
  assign bad_a = use_bits[0] && (a >= 32'(RegCount));
  assign bad_b = use_bits[1] && (b >= 32'(RegCount));
  assign bad_c = use_bits[2] && (c >= 32'(RegCount));
  assign frame_idx = {{(33-DepthW){1'b0}}, fbase} +
                     {1'b0, ((op == OP_STORE) ? a : b)};
  // The frame is only built when the saved base, the locals and the return
  // address all fit; otherwise the stack RAM is left untouched.
  assign call_fit = !halt &&
                    ({24'd0, depth} + {1'b0, c} + 33'd2 <= 33'(StackWords));

  assign status.call_fit  = call_fit;
  assign status.bad_idx   = bad_a || bad_b || bad_c;
  assign status.bad_op    = use_bits[3];
  assign status.div_busy  = div_busy;
  assign status.zero_done = (zcount == '0);
  assign status.op        = op;

  bvm_ram #(.Width(32), .Depth(StackWords)) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bvm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(rb),
    .divisor ((op == OP_DIVI) ? c : rc),
    .busy    (div_busy),
    .quotient(div_q)
  );

  assign div_start = (cmd == DC_DIV_START);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = depth[StackIdxW-1:0];
    ram_wdata = ra;
    ram_raddr = depth[StackIdxW-1:0] - StackIdxW'(1);
    unique case (cmd)
      DC_STK_RD: begin
        if (op == OP_LOAD) ram_raddr = frame_idx[StackIdxW-1:0];
        else ram_raddr = depth[StackIdxW-1:0] - StackIdxW'(1);
      end
      DC_RET_RD_SAVED: ram_raddr = fbase[StackIdxW-1:0] - StackIdxW'(1);
      DC_EXEC: begin
        if (!halt && !use_bits[3] && !(bad_a || bad_b || bad_c)) begin
          if (op == OP_PUSH && depth < DepthW'(StackWords)) begin
            ram_we = 1'b1;
          end else if (op == OP_STORE && frame_idx < 33'(depth)) begin
            ram_we    = 1'b1;
            ram_waddr = frame_idx[StackIdxW-1:0];
            ram_wdata = rb;
          end
        end
      end
      DC_CALL_BASE: begin
        ram_we    = 1'b1;
        ram_wdata = 32'(fbase);
      end
      DC_CALL_ZERO: begin
        ram_we    = (zcount != '0);
        ram_waddr = zaddr[StackIdxW-1:0];
        ram_wdata = '0;
      end
      DC_CALL_RET: begin
        ram_we    = 1'b1;
        ram_waddr = zaddr[StackIdxW-1:0];
        ram_wdata = pc + 32'd1;
      end
      default: ;
    endcase
  end

  // Register operands are read in the decode step; results land at DC_EXEC.
  always_ff @(posedge clk) begin
    logic [31:0] npc;
    logic [2:0]  flt;
    logic        wr;
    logic [31:0] wv;
    npc = pc + 32'd1;
    flt = FLT_NONE;
    wr  = 1'b0;
    wv  = '0;
    if (rst) begin
      pc    <= '0;
      depth <= '0;
      fbase <= '0;
      halt  <= 1'b0;
      for (int i = 0; i < RegCount; i++) regs[i] <= '0;
    end else begin
      if (cfg_we) pc <= cfg_data;
      unique case (cmd)
        DC_LATCH: begin
          op    <= command;
          a     <= operand_a;
          b     <= operand_b;
          c     <= operand_c;
          inval <= input_value;
        end
        DC_DECODE: begin
          ra <= regs[a[RegIdxW-1:0]];
          rb <= regs[b[RegIdxW-1:0]];
          rc <= regs[c[RegIdxW-1:0]];
        end
        DC_CALL_BASE: begin
          zaddr  <= depth + DepthW'(1);
          zcount <= c;
        end
        DC_CALL_ZERO: begin
          if (zcount != '0) begin
            zaddr  <= zaddr + DepthW'(1);
            zcount <= zcount - 32'd1;
          end
        end
        // The return address read at dispatch is on the RAM output now.
        DC_RET_RD_SAVED: stk_word <= ram_rdata;
        DC_EXEC: begin
          if (halt) begin
            npc = pc;
          end else if (use_bits[3]) begin
            flt = FLT_OPC;
          end else if (bad_a || bad_b || bad_c) begin
            flt = FLT_INDEX;
          end else begin
            unique case (op)
              OP_EXIT: begin
                halt <= 1'b1;
                npc = pc;
              end
              OP_STORE: if (frame_idx >= 33'(depth)) flt = FLT_INDEX;
              OP_LOAD: begin
                if (frame_idx >= 33'(depth)) flt = FLT_INDEX;
                else begin wr = 1'b1; wv = ram_rdata; end
              end
              OP_PUSH: begin
                if (depth >= DepthW'(StackWords)) flt = FLT_OVER;
                else depth <= depth + DepthW'(1);
              end
              OP_POP: begin
                if (depth == '0) flt = FLT_UNDER;
                else begin
                  depth <= depth - DepthW'(1);
                  wr = 1'b1;
                  wv = ram_rdata;
                end
              end
              OP_COPY: begin wr = 1'b1; wv = rb; end
              OP_CASL: begin wr = (ra == rb); wv = rc; end
              OP_ADDA: begin wr = 1'b1; wv = ra + rb; end
              OP_SUBA: begin wr = 1'b1; wv = ra - rb; end
              OP_ANDA: begin wr = 1'b1; wv = ra & rb; end
              OP_ORA:  begin wr = 1'b1; wv = ra | rb; end
              OP_ADD:  begin wr = 1'b1; wv = rb + rc; end
              OP_SUB:  begin wr = 1'b1; wv = rb - rc; end
              OP_MUL:  begin wr = 1'b1; wv = rb * rc; end
              OP_DIV: begin
                if (rc == '0) flt = FLT_DIV0;
                else begin wr = 1'b1; wv = div_q; end
              end
              OP_ADDI: begin wr = 1'b1; wv = rb + c; end
              OP_SUBI: begin wr = 1'b1; wv = rb - c; end
              OP_MULI: begin wr = 1'b1; wv = rb * c; end
              OP_DIVI: begin
                if (c == '0) flt = FLT_DIV0;
                else begin wr = 1'b1; wv = div_q; end
              end
              OP_GT:   begin wr = 1'b1; wv = 32'(rb > rc); end
              OP_GE:   begin wr = 1'b1; wv = 32'(rb >= rc); end
              OP_EQ:   begin wr = 1'b1; wv = 32'(rb == rc); end
              OP_CONST: begin wr = 1'b1; wv = b; end
              OP_LAND: begin wr = 1'b1; wv = 32'((rb != '0) && (rc != '0)); end
              OP_LOR:  begin wr = 1'b1; wv = 32'((rb != '0) || (rc != '0)); end
              OP_NOT:  begin wr = 1'b1; wv = 32'(rb == '0); end
              OP_GOTO: npc = pc + a;
              OP_BACK: npc = pc - a;
              OP_IFGT: if (rb > rc) npc = pc + a;
              OP_IFGE: if (rb >= rc) npc = pc + a;
              OP_IFEQ: if (rb == rc) npc = pc + a;
              OP_IOUT: ;
              OP_IIN:  begin wr = 1'b1; wv = inval; end
              OP_CALL: begin
                if ({24'd0, depth} + {1'b0, c} + 33'd2 > 33'(StackWords)) begin
                  flt = FLT_OVER;
                end else begin
                  fbase <= depth + DepthW'(1);
                  depth <= zaddr + DepthW'(1);
                  npc = b;
                end
              end
              OP_RET: begin
                if (depth == '0 || fbase == '0) flt = FLT_UNDER;
                else if (ram_rdata > 32'(fbase - DepthW'(1))) flt = FLT_INDEX;
                else begin
                  depth <= fbase - DepthW'(1);
                  fbase <= ram_rdata[DepthW-1:0];
                  npc = stk_word;
                end
              end
              OP_SHLR: begin wr = 1'b1; wv = (rc >= 32'd32) ? '0 : rb << rc[4:0]; end
              OP_SHRR: begin wr = 1'b1; wv = (rc >= 32'd32) ? '0 : rb >> rc[4:0]; end
              OP_SHLI: begin wr = 1'b1; wv = (c >= 32'd32) ? '0 : rb << c[4:0]; end
              OP_SHRI: begin wr = 1'b1; wv = (c >= 32'd32) ? '0 : rb >> c[4:0]; end
              default: ;
            endcase
          end
          if (flt != FLT_NONE) begin
            npc = pc + 32'd1;
            wr  = 1'b0;
          end
          if (wr) regs[a[RegIdxW-1:0]] <= wv;
          pc <= npc;
          res_next_pc   <= npc;
          res_out_valid <= !halt && flt == FLT_NONE && op == OP_IOUT;
          res_out_value <= (!halt && flt == FLT_NONE && op == OP_IOUT) ? ra : '0;
          res_halted    <= halt || (flt == FLT_NONE && op == OP_EXIT && !use_bits[3]);
          res_fault     <= flt;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/bvm_ctrl.sv]
module bvm_ctrl
  import bvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       res_valid,
  input  logic       res_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DISPATCH, S_DIV, S_RD, S_ZERO, S_CALLRET,
    S_EXEC, S_OUT
  } state_t;

  state_t state;

  // The result registers are rewritten by the next item, so a new item waits
  // until the previous result item has been taken.
  assign in_ready = (state == S_IDLE) && !res_valid;

  always_comb begin
    cmd = DC_NONE;
    unique case (state)
      S_IDLE:     cmd = (in_valid && !res_valid) ? DC_LATCH : DC_NONE;
      S_DECODE:   cmd = DC_DECODE;
      S_DISPATCH: begin
        if (status.bad_op || status.bad_idx) cmd = DC_NONE;
        else if (status.op == OP_DIV || status.op == OP_DIVI) cmd = DC_DIV_START;
        else if (status.op == OP_LOAD || status.op == OP_POP || status.op == OP_RET)
          cmd = DC_STK_RD;
        else if (status.op == OP_CALL && status.call_fit) cmd = DC_CALL_BASE;
        else cmd = DC_NONE;
      end
      S_DIV:      cmd = DC_NONE;
      S_RD:       cmd = DC_RET_RD_SAVED;
      S_ZERO:     cmd = DC_CALL_ZERO;
      S_CALLRET:  cmd = DC_CALL_RET;
      S_EXEC:     cmd = DC_EXEC;
      S_OUT:      cmd = DC_NONE;
      default:    cmd = DC_NONE;
    endcase
  end

  // STORE writes only after the index check, so it goes through S_EXEC via a
  // guarded write issued there by the datapath compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !res_valid) state <= S_DECODE;
        S_DECODE: state <= S_DISPATCH;
        S_DISPATCH: begin
          if (status.bad_op || status.bad_idx) state <= S_EXEC;
          else if (status.op == OP_DIV || status.op == OP_DIVI) state <= S_DIV;
          else if (status.op == OP_RET) state <= S_RD;
          else if (status.op == OP_CALL && status.call_fit) state <= S_ZERO;
          else state <= S_EXEC;
        end
        S_DIV: if (!status.div_busy) state <= S_EXEC;
        S_RD: state <= S_EXEC;
        S_ZERO: if (status.zero_done) state <= S_CALLRET;
        S_CALLRET: state <= S_EXEC;
        S_EXEC: state <= S_OUT;
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/bytecode_register_vm_core_unit.sv]
// Executes one instruction per accepted item and returns one result item
// holding next_pc, the integer output, the halt flag and the fault code.
// The result item is presented after the DECODE, DISPATCH, EXEC and OUT
// states for most opcodes; RET adds RD; divisions wait in DIV for the
// radix-2 divider; a CALL whose frame fits on the stack adds ZERO and
// CALLRET, with locals cleared one stack RAM word a cycle. A new item is
// taken only once the previous result item has been accepted.
module bytecode_register_vm_core_unit
  import bvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  command,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic [31:0] operand_c,
  input  logic [31:0] input_value,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [31:0] next_pc,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        halted,
  output logic [2:0]  fault,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .cmd      (cmd),
    .status   (status)
  );

  bvm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .command      (command),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .operand_c    (operand_c),
    .input_value  (input_value),
    .res_next_pc  (next_pc),
    .res_out_valid(out_valid),
    .res_out_value(out_value),
    .res_halted   (halted),
    .res_fault    (fault)
  );

endmodule

[rtl/core/bvm_checker.sv]
module bvm_checker
  import bvm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        out_valid,
  input logic        halted,
  input logic [2:0]  fault
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !res_valid || $past(res_valid))
    else $error("result appeared right after accept");

  a_fault_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> fault <= FLT_OPC)
    else $error("fault code out of range");

  a_out_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> fault == FLT_NONE && !halted)
    else $error("output with fault or halt");

endmodule

bind bytecode_register_vm_core_unit bvm_checker u_bvm_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .out_valid(out_valid),
  .halted   (halted),
  .fault    (fault)
);
